@@ design/asc_pkg.sv @@
// Token kinds, grammar positions, status codes and grammar tables for the syntax checker.
package asc_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned PosW  = 6;

  // token kinds
  localparam logic [KindW-1:0] K_MEM     = 5'd0;
  localparam logic [KindW-1:0] K_MEM_ID  = 5'd1;
  localparam logic [KindW-1:0] K_NUM     = 5'd2;
  localparam logic [KindW-1:0] K_REG     = 5'd3;
  localparam logic [KindW-1:0] K_REG_ID  = 5'd4;
  localparam logic [KindW-1:0] K_FUNC    = 5'd5;
  localparam logic [KindW-1:0] K_ID      = 5'd6;
  localparam logic [KindW-1:0] K_COLON   = 5'd7;
  localparam logic [KindW-1:0] K_SEMI    = 5'd8;
  localparam logic [KindW-1:0] K_EOF     = 5'd9;
  localparam logic [KindW-1:0] K_ADD     = 5'd10;
  localparam logic [KindW-1:0] K_ADDI    = 5'd11;
  localparam logic [KindW-1:0] K_SUB     = 5'd12;
  localparam logic [KindW-1:0] K_LA      = 5'd13;
  localparam logic [KindW-1:0] K_LW      = 5'd14;
  localparam logic [KindW-1:0] K_LI      = 5'd15;
  localparam logic [KindW-1:0] K_SW      = 5'd16;
  localparam logic [KindW-1:0] K_B       = 5'd17;
  localparam logic [KindW-1:0] K_BLTZ    = 5'd18;
  localparam logic [KindW-1:0] K_NOP     = 5'd19;
  localparam logic [KindW-1:0] K_MULT    = 5'd20;
  localparam logic [KindW-1:0] K_DIV     = 5'd21;
  localparam logic [KindW-1:0] K_LUI     = 5'd22;
  localparam logic [KindW-1:0] K_JR      = 5'd23;
  localparam logic [KindW-1:0] K_COMMA   = 5'd24;
  localparam logic [KindW-1:0] K_LPAR    = 5'd25;
  localparam logic [KindW-1:0] K_RPAR    = 5'd26;

  // expected kind with a top bit that marks "nothing matches"
  localparam logic [KindW:0] NO_KIND = 6'h3F;

  // grammar positions
  localparam logic [PosW-1:0] POS_FIRST = 6'd0;
  localparam logic [PosW-1:0] POS_NEXT  = 6'd1;
  localparam logic [PosW-1:0] POS_LABEL = 6'd2;
  localparam logic [PosW-1:0] POS_MEM   = 6'd3;
  localparam logic [PosW-1:0] POS_REG   = 6'd6;
  localparam logic [PosW-1:0] POS_FUNC  = 6'd8;
  localparam logic [PosW-1:0] POS_LBL   = 6'd10;
  localparam logic [PosW-1:0] POS_ADD   = 6'd11;
  localparam logic [PosW-1:0] POS_ADDI  = 6'd17;
  localparam logic [PosW-1:0] POS_LA    = 6'd23;
  localparam logic [PosW-1:0] POS_LW    = 6'd27;
  localparam logic [PosW-1:0] POS_LI    = 6'd34;
  localparam logic [PosW-1:0] POS_BLTZ  = 6'd38;
  localparam logic [PosW-1:0] POS_NOP   = 6'd42;
  localparam logic [PosW-1:0] POS_MULT  = 6'd43;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ERR  = 3'd1,
    ST_IGN  = 3'd2,
    ST_PASS = 3'd3,
    ST_FAIL = 3'd4
  } asc_status_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            err;
  } asc_state_t;

  typedef struct packed {
    asc_status_t status;
    logic        closed;
  } asc_result_t;

  // position entered by a statement-opening token; POS_FIRST means it cannot open one
  function automatic logic [PosW-1:0] start_pos(input logic [KindW-1:0] tk);
    logic [PosW-1:0] p;
    case (tk)
      K_MEM:          p = POS_MEM;
      K_REG, K_JR:    p = POS_REG;
      K_FUNC, K_B:    p = POS_FUNC;
      K_ID:           p = POS_LBL;
      K_ADD, K_SUB:   p = POS_ADD;
      K_ADDI:         p = POS_ADDI;
      K_LA:           p = POS_LA;
      K_LW, K_SW:     p = POS_LW;
      K_LI, K_LUI:    p = POS_LI;
      K_BLTZ:         p = POS_BLTZ;
      K_NOP:          p = POS_NOP;
      K_MULT, K_DIV:  p = POS_MULT;
      default:        p = POS_FIRST;
    endcase
    return p;
  endfunction

  // token expected at each mid-statement position
  function automatic logic [KindW:0] expect_kind(input logic [PosW-1:0] pos);
    logic [KindW-1:0] k;
    logic             none;
    none = 1'b0;
    case (pos)
      6'd3:  k = K_MEM_ID;
      6'd4:  k = K_NUM;
      6'd5:  k = K_SEMI;
      6'd6:  k = K_REG_ID;
      6'd7:  k = K_SEMI;
      6'd8:  k = K_ID;
      6'd9:  k = K_SEMI;
      6'd10: k = K_COLON;
      6'd11: k = K_REG_ID;
      6'd12: k = K_COMMA;
      6'd13: k = K_REG_ID;
      6'd14: k = K_COMMA;
      6'd15: k = K_REG_ID;
      6'd16: k = K_SEMI;
      6'd17: k = K_REG_ID;
      6'd18: k = K_COMMA;
      6'd19: k = K_REG_ID;
      6'd20: k = K_COMMA;
      6'd21: k = K_NUM;
      6'd22: k = K_SEMI;
      6'd23: k = K_REG_ID;
      6'd24: k = K_COMMA;
      6'd25: k = K_MEM_ID;
      6'd26: k = K_SEMI;
      6'd27: k = K_REG_ID;
      6'd28: k = K_COMMA;
      6'd29: k = K_NUM;
      6'd30: k = K_LPAR;
      6'd31: k = K_REG_ID;
      6'd32: k = K_RPAR;
      6'd33: k = K_SEMI;
      6'd34: k = K_REG_ID;
      6'd35: k = K_COMMA;
      6'd36: k = K_NUM;
      6'd37: k = K_SEMI;
      6'd38: k = K_REG_ID;
      6'd39: k = K_COMMA;
      6'd40: k = K_ID;
      6'd41: k = K_SEMI;
      6'd42: k = K_SEMI;
      6'd43: k = K_REG_ID;
      6'd44: k = K_COMMA;
      6'd45: k = K_REG_ID;
      6'd46: k = K_SEMI;
      default: begin
        k    = K_MEM;
        none = 1'b1;
      end
    endcase
    return none ? NO_KIND : {1'b0, k};
  endfunction

endpackage

@@ design/asc_if.sv @@
// Request channel interfaces: token input and status output.
interface asc_in_if;
  logic                        valid;
  logic                        ready;
  logic [asc_pkg::KindW-1:0]   token_kind;

  modport source (output valid, output token_kind, input ready);
  modport sink   (input valid, input token_kind, output ready);
endinterface

interface asc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       statement_closed;

  modport source (output valid, output status, output statement_closed, input ready);
  modport sink   (input valid, input status, input statement_closed, output ready);
endinterface

@@ design/asc_step.sv @@
// One grammar transition: next position, error flag and status for one token.
module asc_step (
  input  asc_pkg::asc_state_t          cur,
  input  logic [asc_pkg::KindW-1:0]    tk,
  output asc_pkg::asc_state_t          nxt,
  output asc_pkg::asc_result_t         res
);
  import asc_pkg::*;

  logic [PosW-1:0]  st;
  logic [KindW:0]   ex;
  logic             mnemonic;

  assign st       = start_pos(tk);
  assign ex       = expect_kind(cur.pos);
  assign mnemonic = (tk >= K_ADD) && (tk <= K_JR);

  always_comb begin
    nxt        = cur;
    res.status = ST_OK;
    res.closed = 1'b0;
    if (tk == K_EOF) begin
      res.status = (!cur.err && cur.pos == POS_NEXT) ? ST_PASS : ST_FAIL;
      nxt.pos    = POS_FIRST;
      nxt.err    = 1'b0;
    end else if (cur.err) begin
      res.status = ST_IGN;
    end else if (cur.pos <= POS_LABEL) begin
      if (tk == K_SEMI) begin
        res.closed = 1'b1;
        nxt.pos    = POS_NEXT;
      end else if (st != POS_FIRST && (cur.pos != POS_LABEL || mnemonic)) begin
        nxt.pos = st;
      end else begin
        res.status = ST_ERR;
        nxt.err    = 1'b1;
      end
    end else if ({1'b0, tk} == ex) begin
      if (tk == K_SEMI) begin
        res.closed = 1'b1;
        nxt.pos    = POS_NEXT;
      end else if (tk == K_COLON) begin
        nxt.pos = POS_LABEL;
      end else begin
        nxt.pos = cur.pos + 6'd1;
      end
    end else begin
      res.status = ST_ERR;
      nxt.err    = 1'b1;
    end
  end

endmodule

@@ design/assembly_syntax_checker.sv @@
// Top level of the assembly syntax checker: grammar state and result register.
// Takes one token kind per cycle unless the output stalls and returns one status per
// token in the cycle after it is accepted. The grammar step is a single table lookup
// and compare between the position and result registers, so a token is taken whenever
// in_ch.ready is high, that is when the result register is empty or being drained in
// the same cycle. After an error, tokens are reported as ignored until end-of-file,
// which reports the verdict and returns the checker to the start of a new program.
module assembly_syntax_checker (
  input  logic       clk,
  input  logic       rst_n,
  asc_in_if.sink     in_ch,
  asc_out_if.source  out_ch
);
  import asc_pkg::*;

  asc_state_t   state_r;
  asc_state_t   state_nxt;
  asc_result_t  res_nxt;
  asc_result_t  res_r;
  logic         out_valid_r;
  logic         accept;

  asc_step u_step (
    .cur (state_r),
    .tk  (in_ch.token_kind),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pos <= POS_FIRST;
      state_r.err <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = res_r.status;
  assign out_ch.statement_closed = res_r.closed;

  a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.token_kind == K_EOF |=> state_r.pos == POS_FIRST && !state_r.err)
    else $error("end-of-file did not return the checker to its start");

  a_closed_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_nxt.closed |=> state_r.pos == POS_NEXT)
    else $error("closed statement did not move to next statement start");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_nxt.status == ST_ERR |=> state_r.err)
    else $error("syntax error did not set the error flag");

  a_closed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.closed |-> res_r.status == ST_OK)
    else $error("statement closed reported with a non-accepted status");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while result register is empty");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the assembly syntax checker: token programs in, status checked.
module testbench;
  import asc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_TOKENS = 650;
  localparam logic [PosW-1:0] POS_LAST = 6'd46;
  // kinds with no grammar role
  localparam logic [KindW-1:0] K_OTHER  = 5'd27;
  localparam logic [KindW-1:0] K_SPARE  = 5'd31;

  typedef struct {
    logic [KindW-1:0] kind;
    bit               pinned;
    asc_result_t      want;
  } token_req_t;

  logic clk;
  logic rst_n;

  asc_in_if  tok_ch ();
  asc_out_if res_ch ();

  assembly_syntax_checker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tok_ch),
    .out_ch (res_ch)
  );

  // tokens expected from the first mid-statement position onwards,
  // one statement shape after another
  logic [KindW-1:0] grammar_body [44] = '{
    K_MEM_ID, K_NUM, K_SEMI,
    K_REG_ID, K_SEMI,
    K_ID, K_SEMI,
    K_COLON,
    K_REG_ID, K_COMMA, K_REG_ID, K_COMMA, K_REG_ID, K_SEMI,
    K_REG_ID, K_COMMA, K_REG_ID, K_COMMA, K_NUM, K_SEMI,
    K_REG_ID, K_COMMA, K_MEM_ID, K_SEMI,
    K_REG_ID, K_COMMA, K_NUM, K_LPAR, K_REG_ID, K_RPAR, K_SEMI,
    K_REG_ID, K_COMMA, K_NUM, K_SEMI,
    K_REG_ID, K_COMMA, K_ID, K_SEMI,
    K_SEMI,
    K_REG_ID, K_COMMA, K_REG_ID, K_SEMI
  };

  // where each token kind lands when it opens a statement
  logic [PosW-1:0] open_at [32] = '{
    POS_MEM, POS_FIRST, POS_FIRST, POS_REG, POS_FIRST, POS_FUNC, POS_LBL, POS_FIRST,
    POS_FIRST, POS_FIRST, POS_ADD, POS_ADDI, POS_ADD, POS_LA, POS_LW, POS_LI,
    POS_LW, POS_FUNC, POS_BLTZ, POS_NOP, POS_MULT, POS_MULT, POS_LI, POS_REG,
    POS_FIRST, POS_FIRST, POS_FIRST, POS_FIRST, POS_FIRST, POS_FIRST, POS_FIRST, POS_FIRST
  };

  logic [PosW-1:0] gram_pos;
  logic            gram_err;
  token_req_t      token_feed [$];
  asc_result_t     status_due [$];
  int              noise_pct;
  int              fails;
  int              cycles = 0;

  function automatic asc_result_t grammar_step(input logic [KindW-1:0] tk);
    asc_result_t r;
    logic [KindW:0] want_k;
    logic           mnemonic;
    r.status = ST_OK;
    r.closed = 1'b0;
    mnemonic = (tk >= K_ADD) && (tk <= K_JR);
    if (tk == K_EOF) begin
      r.status = (!gram_err && gram_pos == POS_NEXT) ? ST_PASS : ST_FAIL;
      gram_pos = POS_FIRST;
      gram_err = 1'b0;
    end else if (gram_err) begin
      r.status = ST_IGN;
    end else if (gram_pos <= POS_LABEL) begin
      if (tk == K_SEMI) begin
        r.closed = 1'b1;
        gram_pos = POS_NEXT;
      end else if (open_at[tk] != POS_FIRST && (gram_pos != POS_LABEL || mnemonic)) begin
        gram_pos = open_at[tk];
      end else begin
        r.status = ST_ERR;
        gram_err = 1'b1;
      end
    end else begin
      want_k = (gram_pos >= POS_MEM && gram_pos <= POS_LAST) ?
               {1'b0, grammar_body[gram_pos - POS_MEM]} : NO_KIND;
      if ({1'b0, tk} == want_k) begin
        if (tk == K_SEMI) begin
          r.closed = 1'b1;
          gram_pos = POS_NEXT;
        end else if (tk == K_COLON) begin
          gram_pos = POS_LABEL;
        end else begin
          gram_pos = gram_pos + 1'b1;
        end
      end else begin
        r.status = ST_ERR;
        gram_err = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_tok(input logic [KindW-1:0] k);
    token_req_t req;
    req.kind = k;
    if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
      req.kind = KindW'($urandom_range(0, 31));
    req.pinned = 1'b0;
    req.want = '{ST_OK, 1'b0};
    token_feed.push_back(req);
  endtask

  task automatic add_pinned(input logic [KindW-1:0] k, input asc_status_t st, input logic cl);
    token_req_t req;
    req.kind = k;
    req.pinned = 1'b1;
    req.want = '{st, cl};
    token_feed.push_back(req);
  endtask

  task automatic add_instr(input logic [KindW-1:0] mn);
    add_tok(mn);
    case (mn)
      K_ADD, K_SUB: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_REG_ID);
        add_tok(K_COMMA); add_tok(K_REG_ID);
      end
      K_ADDI: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_REG_ID);
        add_tok(K_COMMA); add_tok(K_NUM);
      end
      K_LA: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_MEM_ID);
      end
      K_LW, K_SW: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_NUM);
        add_tok(K_LPAR); add_tok(K_REG_ID); add_tok(K_RPAR);
      end
      K_LI, K_LUI: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_NUM);
      end
      K_B: add_tok(K_ID);
      K_BLTZ: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_ID);
      end
      K_MULT, K_DIV: begin
        add_tok(K_REG_ID); add_tok(K_COMMA); add_tok(K_REG_ID);
      end
      K_JR: add_tok(K_REG_ID);
      default: ;
    endcase
  endtask

  task automatic add_statement();
    int form;
    form = $urandom_range(0, 9);
    case (form)
      0: begin add_tok(K_MEM); add_tok(K_MEM_ID); add_tok(K_NUM); end
      1: begin add_tok(K_REG); add_tok(K_REG_ID); end
      2: begin add_tok(K_FUNC); add_tok(K_ID); end
      3: begin
        add_tok(K_ID);
        add_tok(K_COLON);
        if ($urandom_range(0, 1) == 1) add_instr(KindW'($urandom_range(K_ADD, K_JR)));
      end
      4: ;
      default: add_instr(KindW'($urandom_range(K_ADD, K_JR)));
    endcase
    add_tok(K_SEMI);
  endtask

  task automatic add_program();
    int style;
    int first;
    int cut;
    style = $urandom_range(0, 9);
    first = token_feed.size();
    if (style == 0) begin
      // pure noise, may hold stray end-of-file tokens of its own
      noise_pct = 0;
      repeat ($urandom_range(0, 8)) add_tok(KindW'($urandom_range(0, 31)));
    end else begin
      noise_pct = (style <= 2) ? $urandom_range(3, 15) : 0;
      repeat ($urandom_range(1, 6)) add_statement();
      if (style == 3) begin
        // end-of-file arrives mid-statement
        cut = $urandom_range(1, 2);
        if (token_feed.size() > first + cut) repeat (cut) void'(token_feed.pop_back());
      end
    end
    noise_pct = 0;
    add_tok(K_EOF);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : drive_tokens
    token_req_t  req;
    asc_result_t due;
    int          gap;
    bit          burst;
    tok_ch.valid      <= 1'b0;
    tok_ch.token_kind <= '0;
    gram_pos = POS_FIRST;
    gram_err = 1'b0;
    noise_pct = 0;
    fails = 0;
    burst = 1'b0;

    // directed programs
    add_pinned(K_EOF, ST_FAIL, 1'b0);
    add_pinned(K_SEMI, ST_OK, 1'b1);
    add_pinned(K_EOF, ST_PASS, 1'b0);
    add_tok(K_MEM); add_tok(K_MEM_ID); add_tok(K_NUM); add_tok(K_SEMI);
    add_tok(K_ID); add_tok(K_COLON); add_tok(K_SEMI);
    add_tok(K_ID); add_tok(K_COLON); add_tok(K_NOP); add_tok(K_SEMI);
    add_pinned(K_EOF, ST_PASS, 1'b0);
    add_pinned(K_SPARE, ST_ERR, 1'b0);
    add_pinned(K_MEM, ST_IGN, 1'b0);
    add_pinned(K_EOF, ST_FAIL, 1'b0);
    add_pinned(K_OTHER, ST_ERR, 1'b0);
    add_pinned(K_EOF, ST_FAIL, 1'b0);
    add_tok(K_MEM);
    add_pinned(K_EOF, ST_FAIL, 1'b0);
    add_tok(K_ID); add_tok(K_COLON);
    add_pinned(K_ID, ST_ERR, 1'b0);
    add_pinned(K_EOF, ST_FAIL, 1'b0);

    while (token_feed.size() < 27 + RANDOM_TOKENS) add_program();

    while (rst_n !== 1'b1) @(posedge clk);

    for (int i = 0; i < token_feed.size(); i++) begin
      req = token_feed[i];
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        tok_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tok_ch.valid      <= 1'b1;
      tok_ch.token_kind <= req.kind;
      do @(posedge clk); while (!tok_ch.ready);
      due = grammar_step(req.kind);
      if (req.pinned) due = req.want;
      status_due.push_back(due);
    end
    tok_ch.valid <= 1'b0;

    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : take_results
    asc_result_t want;
    int          stall;
    int          n;
    bit          burst;
    res_ch.ready <= 1'b0;
    n = 0;
    burst = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      n++;
      stall = burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d closed %0b",
                 $time, res_ch.status, res_ch.statement_closed);
        fails++;
      end else begin
        want = status_due.pop_front();
        if (res_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, res_ch.status);
          fails++;
        end
        if (res_ch.statement_closed !== want.closed) begin
          $display("%0t: statement_closed mismatch, expected %0b, got %0b",
                   $time, want.closed, res_ch.statement_closed);
          fails++;
        end
      end
    end
  end

endmodule
